@@ hdl/link_health_quality_controller_assert.svh @@
// Assertion macros shared by the link health checker.
// Each expects aclk and aresetn in the scope where it is used.
`ifndef LINK_HEALTH_QUALITY_CONTROLLER_ASSERT_SVH
`define LINK_HEALTH_QUALITY_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define LHQC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define LHQC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/lhqc_pkg.sv @@
`default_nettype none

package lhqc_pkg;

    localparam int QUAL_W   = 7;
    localparam int HEALTH_W = 14;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    typedef logic [QUAL_W-1:0]   quality_t;
    typedef logic [HEALTH_W-1:0] health_t;
    typedef logic [APB_AW-1:0]   apb_addr_t;
    typedef logic [APB_DW-1:0]   apb_data_t;
    typedef logic [1:0]          reg_idx_t;

    // Register map, index = paddr[3:2]
    localparam reg_idx_t REG_AUTO_ENABLE     = 2'd0;
    localparam reg_idx_t REG_LINK_MODE       = 2'd1;
    localparam reg_idx_t REG_QUALITY_CEILING = 2'd2;
    localparam reg_idx_t REG_QUALITY_FLOOR   = 2'd3;

    localparam quality_t CEILING_RESET = 7'd75;
    localparam quality_t FLOOR_RESET   = 7'd10;

    localparam health_t HEALTH_FULL   = 14'd10000;
    localparam health_t HEALTH_IGNORE = 14'd2500;
    localparam health_t HEALTH_DROP   = 14'd9000;
    localparam health_t HEALTH_RISE   = 14'd9750;

    // Decrease step: floor(x / 100000) for x < 2^24 is (x * DECREASE_RECIP) >> DECREASE_SHIFT
    localparam logic [24:0] DECREASE_RECIP = 25'd21990233;
    localparam int          DECREASE_SHIFT = 41;

    function automatic health_t health_sat(input health_t h);
        health_sat = (h > HEALTH_FULL) ? HEALTH_FULL : h;
    endfunction

endpackage

`default_nettype wire

@@ hdl/link_health_quality_controller.sv @@
// Link health and AIMD quality controller, one transaction at a time.
// Sequence: UDP with no frames received goes straight to the quality step, else a multiply
// and a bit-serial divide; reliable multiplies, divides by the FEC count, may square the ratio.
// s_ready is high only while idle, and a result still waiting on m_ready holds the
// sequencer in its last state.
// Reset: synchronous active-low aresetn clears sequencer, quality state, output valid.
`default_nettype none

module link_health_quality_controller #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        psel,
    input  wire                        penable,
    input  wire                        pwrite,
    input  lhqc_pkg::apb_addr_t        paddr,
    input  lhqc_pkg::apb_data_t        pwdata,
    output lhqc_pkg::apb_data_t        prdata,
    output logic                       pready,
    input  wire                        s_valid,
    output logic                       s_ready,
    input  wire  [COUNT_WIDTH-1:0]     s_fec_count,
    input  wire  [COUNT_WIDTH-1:0]     s_packet_id_count,
    input  wire  [COUNT_WIDTH-1:0]     s_frame_id_count,
    input  wire  [COUNT_WIDTH-1:0]     s_packets_received,
    input  wire  [COUNT_WIDTH-1:0]     s_frames_received,
    input  wire  [COUNT_WIDTH-1:0]     s_frames_lost,
    output logic                       m_valid,
    input  wire                        m_ready,
    output lhqc_pkg::quality_t         m_quality,
    output lhqc_pkg::health_t          m_health_hundredths,
    output logic                       m_had_traffic
);
    import lhqc_pkg::*;

    localparam int CW    = COUNT_WIDTH;
    localparam int MW    = (CW > 32) ? CW : 32;           // multiplier operand width
    localparam int PW    = 2 * MW;                        // product width
    localparam int DW    = (2 * CW > 17) ? 2 * CW : 17;   // divisor width
    localparam int RW    = DW + 1;                        // partial remainder width
    localparam int QW    = (2 * CW > 16) ? 2 * CW : 16;   // dividend/quotient shifter
    localparam int K_EXP = 2 * CW;
    localparam int K_RAT = 16;
    localparam int K_UDP = 14;
    localparam int CNW   = $clog2(QW + 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MUL   = 4'd1;
    localparam logic [3:0] ST_DIV   = 4'd2;
    localparam logic [3:0] ST_EXP   = 4'd3;
    localparam logic [3:0] ST_RAT   = 4'd4;
    localparam logic [3:0] ST_SQ    = 4'd5;
    localparam logic [3:0] ST_SQ2   = 4'd6;
    localparam logic [3:0] ST_RH    = 4'd7;
    localparam logic [3:0] ST_UDIV  = 4'd8;
    localparam logic [3:0] ST_UH    = 4'd9;
    localparam logic [3:0] ST_QSTEP = 4'd10;
    localparam logic [3:0] ST_DEC   = 4'd11;
    localparam logic [3:0] ST_DQ    = 4'd12;
    localparam logic [3:0] ST_CLAMP = 4'd13;
    localparam logic [3:0] ST_DONE  = 4'd14;

    logic [3:0]     state_reg, state_next;
    logic [3:0]     ret_reg, ret_next;
    logic [CNW-1:0] cnt_reg, cnt_next;
    logic [RW-1:0]  rem_reg, rem_next;
    logic [QW-1:0]  sh_reg, sh_next;
    logic [DW-1:0]  d_reg, d_next;
    logic [MW-1:0]  a_reg, a_next;
    logic [MW-1:0]  b_reg, b_next;
    logic [PW-1:0]  prod_reg, prod_next;
    logic [CW-1:0]  fec_reg, fec_next;
    logic [CW-1:0]  recv_reg, recv_next;
    health_t        health_reg, health_next;
    logic           traffic_reg, traffic_next;
    logic [7:0]     qc_reg, qc_next;
    quality_t       cur_q_reg, cur_q_next;
    quality_t       ceil_seen_reg, ceil_seen_next;
    logic [1:0]     cool_reg, cool_next;
    logic           auto_en_reg, auto_en_next;
    logic           mode_reg, mode_next;
    quality_t       ceil_reg, ceil_next;
    quality_t       floor_reg, floor_next;
    logic           m_valid_reg, m_valid_next;
    quality_t       m_quality_reg, m_quality_next;
    health_t        m_health_reg, m_health_next;
    logic           m_traffic_reg, m_traffic_next;

    logic              apb_wr;
    logic [RW-1:0]     rem_sh;
    logic [RW-1:0]     rem_dif;
    logic              q_bit;
    logic [CW:0]       udp_total;
    logic [16:0]       health9;
    logic signed [7:0] gap;
    logic [7:0]        q_inc;
    quality_t          q_clamp;
    logic [DW-1:0]     expected;

    assign pready  = 1'b1;
    assign apb_wr  = psel && penable && pwrite;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_quality = m_quality_reg;
    assign m_health_hundredths = m_health_reg;
    assign m_had_traffic = m_traffic_reg;

    always_comb begin
        unique case (paddr[3:2])
            REG_AUTO_ENABLE:     prdata = APB_DW'(auto_en_reg);
            REG_LINK_MODE:       prdata = APB_DW'(mode_reg);
            REG_QUALITY_CEILING: prdata = APB_DW'(ceil_reg);
            REG_QUALITY_FLOOR:   prdata = APB_DW'(floor_reg);
            default:             prdata = '0;
        endcase
    end

    // Shared restoring divider step: one quotient bit per cycle
    assign rem_sh  = {rem_reg[RW-2:0], sh_reg[QW-1]};
    assign q_bit   = (rem_sh >= {1'b0, d_reg});
    assign rem_dif = rem_sh - {1'b0, d_reg};

    assign udp_total = {1'b0, s_frames_received} + {1'b0, s_frames_lost};
    assign health9   = {health_reg, 3'b000} + 17'(health_reg);
    assign gap       = $signed({1'b0, ceil_seen_reg}) - $signed({1'b0, cur_q_reg});
    assign q_inc     = (gap > 8'sd25) ? 8'd5 : ((gap > 8'sd10) ? 8'd3 : 8'd1);
    assign expected  = DW'(sh_reg[K_EXP-1:0]);

    always_comb begin
        if (qc_reg < {1'b0, floor_reg}) begin
            q_clamp = floor_reg;
        end else if (qc_reg > {1'b0, ceil_seen_reg}) begin
            q_clamp = ceil_seen_reg;
        end else begin
            q_clamp = qc_reg[QUAL_W-1:0];
        end
    end

    always_comb begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        sh_next        = sh_reg;
        d_next         = d_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        prod_next      = prod_reg;
        fec_next       = fec_reg;
        recv_next      = recv_reg;
        health_next    = health_reg;
        traffic_next   = traffic_reg;
        qc_next        = qc_reg;
        cur_q_next     = cur_q_reg;
        ceil_seen_next = ceil_seen_reg;
        cool_next      = cool_reg;
        auto_en_next   = auto_en_reg;
        mode_next      = mode_reg;
        ceil_next      = ceil_reg;
        floor_next     = floor_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_quality_next = m_quality_reg;
        m_health_next  = m_health_reg;
        m_traffic_next = m_traffic_reg;

        if (apb_wr) begin
            unique case (paddr[3:2])
                REG_AUTO_ENABLE:     auto_en_next = pwdata[0];
                REG_LINK_MODE:       mode_next    = pwdata[0];
                REG_QUALITY_CEILING: ceil_next    = pwdata[QUAL_W-1:0];
                REG_QUALITY_FLOOR:   floor_next   = pwdata[QUAL_W-1:0];
                default:             ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (mode_reg) begin
                        a_next     = MW'(s_packet_id_count);
                        b_next     = MW'(s_frame_id_count);
                        fec_next   = s_fec_count;
                        recv_next  = s_packets_received;
                        ret_next   = ST_EXP;
                        state_next = ST_MUL;
                    end else begin
                        traffic_next = (udp_total != '0);
                        d_next       = DW'(udp_total);
                        if (s_frames_received == '0) begin
                            health_next = '0;
                            state_next  = ST_QSTEP;
                        end else begin
                            a_next     = MW'(s_frames_received);
                            b_next     = MW'(HEALTH_FULL);
                            ret_next   = ST_UDIV;
                            state_next = ST_MUL;
                        end
                    end
                end
            end
            ST_MUL: begin
                prod_next  = PW'(a_reg) * PW'(b_reg);
                state_next = ret_reg;
            end
            ST_DIV: begin
                rem_next = q_bit ? rem_dif : rem_sh;
                sh_next  = {sh_reg[QW-2:0], q_bit};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNW'(1)) begin
                    state_next = ret_reg;
                end
            end
            ST_EXP: begin
                // expected = pid * fid / fec
                if (fec_reg == '0) begin
                    traffic_next = 1'b0;
                    health_next  = '0;
                    state_next   = ST_QSTEP;
                end else begin
                    rem_next   = RW'(prod_reg >> K_EXP);
                    sh_next    = QW'(prod_reg << (QW - K_EXP));
                    d_next     = DW'(fec_reg);
                    cnt_next   = CNW'(K_EXP);
                    ret_next   = ST_RAT;
                    state_next = ST_DIV;
                end
            end
            ST_RAT: begin
                traffic_next = (expected != '0);
                if (expected == '0) begin
                    health_next = '0;
                    state_next  = ST_QSTEP;
                end else if (DW'(recv_reg) >= expected) begin
                    health_next = HEALTH_FULL;
                    state_next  = ST_QSTEP;
                end else begin
                    // Q0.16 ratio: (recv << 16) / expected
                    rem_next   = RW'(recv_reg);
                    sh_next    = '0;
                    d_next     = expected;
                    cnt_next   = CNW'(K_RAT);
                    ret_next   = ST_SQ;
                    state_next = ST_DIV;
                end
            end
            ST_SQ: begin
                a_next     = MW'(sh_reg[K_RAT-1:0]);
                b_next     = MW'(sh_reg[K_RAT-1:0]);
                ret_next   = ST_SQ2;
                state_next = ST_MUL;
            end
            ST_SQ2: begin
                a_next     = MW'(prod_reg[31:0]);
                b_next     = MW'(HEALTH_FULL);
                ret_next   = ST_RH;
                state_next = ST_MUL;
            end
            ST_RH: begin
                health_next = health_sat(prod_reg[32 +: HEALTH_W]);
                state_next  = ST_QSTEP;
            end
            ST_UDIV: begin
                rem_next   = RW'(prod_reg >> K_UDP);
                sh_next    = QW'(prod_reg << (QW - K_UDP));
                cnt_next   = CNW'(K_UDP);
                ret_next   = ST_UH;
                state_next = ST_DIV;
            end
            ST_UH: begin
                health_next = health_sat(sh_reg[HEALTH_W-1:0]);
                state_next  = ST_QSTEP;
            end
            ST_QSTEP: begin
                if (!auto_en_reg || cur_q_reg == '0 || ceil_seen_reg != ceil_reg) begin
                    ceil_seen_next = ceil_reg;
                    cur_q_next     = ceil_reg;
                    cool_next      = 2'd2;
                    state_next     = ST_DONE;
                end else if (!traffic_reg || health_reg < HEALTH_IGNORE) begin
                    state_next = ST_DONE;
                end else if (cool_reg != '0) begin
                    cool_next  = cool_reg - 1'b1;
                    state_next = ST_DONE;
                end else if (health_reg < HEALTH_DROP) begin
                    a_next     = MW'(cur_q_reg);
                    b_next     = MW'(health9);
                    ret_next   = ST_DEC;
                    state_next = ST_MUL;
                end else if (health_reg >= HEALTH_RISE) begin
                    qc_next    = {1'b0, cur_q_reg} + q_inc;
                    state_next = ST_CLAMP;
                end else begin
                    qc_next    = {1'b0, cur_q_reg};
                    state_next = ST_CLAMP;
                end
            end
            ST_DEC: begin
                // q*health*9 / 100000 by reciprocal multiply
                a_next     = MW'(prod_reg[31:0]);
                b_next     = MW'(DECREASE_RECIP);
                ret_next   = ST_DQ;
                state_next = ST_MUL;
            end
            ST_DQ: begin
                qc_next    = {1'b0, prod_reg[DECREASE_SHIFT +: QUAL_W]};
                state_next = ST_CLAMP;
            end
            ST_CLAMP: begin
                if (q_clamp != cur_q_reg) begin
                    cool_next = 2'd1;
                end
                cur_q_next = q_clamp;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // hold here while the previous result is still unclaimed
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_quality_next = cur_q_reg;
                    m_health_next  = health_reg;
                    m_traffic_next = traffic_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            cnt_reg       <= '0;
            cur_q_reg     <= '0;
            ceil_seen_reg <= '0;
            cool_reg      <= '0;
            auto_en_reg   <= 1'b0;
            mode_reg      <= 1'b0;
            ceil_reg      <= CEILING_RESET;
            floor_reg     <= FLOOR_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            cnt_reg       <= cnt_next;
            cur_q_reg     <= cur_q_next;
            ceil_seen_reg <= ceil_seen_next;
            cool_reg      <= cool_next;
            auto_en_reg   <= auto_en_next;
            mode_reg      <= mode_next;
            ceil_reg      <= ceil_next;
            floor_reg     <= floor_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg       <= rem_next;
        sh_reg        <= sh_next;
        d_reg         <= d_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        prod_reg      <= prod_next;
        fec_reg       <= fec_next;
        recv_reg      <= recv_next;
        health_reg    <= health_next;
        traffic_reg   <= traffic_next;
        qc_reg        <= qc_next;
        m_quality_reg <= m_quality_next;
        m_health_reg  <= m_health_next;
        m_traffic_reg <= m_traffic_next;
    end

endmodule

`default_nettype wire

@@ hdl/lhqc_checker.sv @@
`default_nettype none

`include "link_health_quality_controller_assert.svh"

module lhqc_checker (
    input wire                    aclk,
    input wire                    aresetn,
    input wire                    s_valid,
    input wire                    s_ready,
    input wire                    m_valid,
    input wire                    m_ready,
    input lhqc_pkg::quality_t     m_quality,
    input lhqc_pkg::health_t      m_health_hundredths,
    input wire                    m_had_traffic
);
    import lhqc_pkg::*;

    logic accept_in;
    logic out_stall;
    logic idle_result;

    assign accept_in   = s_valid && s_ready;
    assign out_stall   = m_valid && !m_ready;
    assign idle_result = m_valid && !m_had_traffic;

    `LHQC_ASSERT_IMP(a_health_range, m_valid, m_health_hundredths <= HEALTH_FULL, "health range")
    `LHQC_ASSERT_IMP(a_idle_health, idle_result, m_health_hundredths == '0, "idle health")
    `LHQC_ASSERT_NXT(a_busy_after_accept, accept_in, !s_ready, "accepted while busy")
    `LHQC_ASSERT_NXT(a_out_hold, out_stall, m_valid && $stable(m_quality), "result changed")

endmodule

bind link_health_quality_controller lhqc_checker u_lhqc_checker (.*);

`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import lhqc_pkg::*;

    typedef struct packed {
        bit [15:0] fec;
        bit [15:0] pid;
        bit [15:0] fid;
        bit [15:0] recv;
        bit [15:0] got;
        bit [15:0] lost;
    } counters_t;

    typedef struct packed {
        quality_t quality;
        health_t  health;
        logic     traffic;
    } outcome_t;

    // Tracks the controller's quality state and queues the outcome of each
    // accepted interval, then checks the block's results against the queue.
    class link_quality_scoreboard;
        bit        auto_en;
        bit        reliable;
        quality_t  ceil_reg;
        quality_t  floor_reg;
        quality_t  cur_q;
        quality_t  ceil_seen;
        bit [1:0]  cooldown;
        outcome_t  expected_outcomes[$];
        int unsigned errors, checked, n_reset, n_drop, n_rise, n_idle, n_writes;

        function new();
            auto_en   = 1'b0;
            reliable  = 1'b0;
            ceil_reg  = CEILING_RESET;
            floor_reg = FLOOR_RESET;
            cur_q     = '0;
            ceil_seen = '0;
            cooldown  = '0;
        endfunction

        function void write_reg(reg_idx_t idx, apb_data_t v);
            n_writes++;
            case (idx)
                REG_AUTO_ENABLE:     auto_en   = v[0];
                REG_LINK_MODE:       reliable  = v[0];
                REG_QUALITY_CEILING: ceil_reg  = v[6:0];
                REG_QUALITY_FLOOR:   floor_reg = v[6:0];
                default: ;
            endcase
        endfunction

        function int unsigned link_health(counters_t c, output bit traffic);
            longint unsigned want, ratio, total;
            int unsigned h;
            if (reliable) begin
                want = (c.fec == 0) ? 64'd0 : (64'(c.pid) * 64'(c.fid)) / 64'(c.fec);
                traffic = (want != 0);
                if (!traffic) begin
                    h = 0;
                end else if (64'(c.recv) >= want) begin
                    h = 32'(HEALTH_FULL);
                end else begin
                    // Q0.16 delivery ratio, squared
                    ratio = (64'(c.recv) << 16) / want;
                    h = 32'((ratio * ratio * 64'd10000) >> 32);
                end
            end else begin
                total = 64'(c.got) + 64'(c.lost);
                traffic = (total != 0);
                h = (c.got == 0) ? 0 : 32'((64'(c.got) * 64'd10000) / total);
            end
            if (h > HEALTH_FULL) h = 32'(HEALTH_FULL);
            return h;
        endfunction

        function void step_quality(int unsigned h, bit traffic);
            int q, prev, gap;
            if (!auto_en || cur_q == 0 || ceil_seen != ceil_reg) begin
                ceil_seen = ceil_reg;
                cur_q     = ceil_reg;
                cooldown  = 2'd2;
                n_reset++;
                return;
            end
            if (!traffic || h < HEALTH_IGNORE) begin
                n_idle++;
                return;
            end
            if (cooldown > 0) begin
                cooldown = cooldown - 2'd1;
                return;
            end
            q = int'(cur_q);
            prev = q;
            if (h < HEALTH_DROP) begin
                q = (q * int'(h) * 9) / 100000;
                n_drop++;
            end else if (h >= HEALTH_RISE) begin
                gap = int'(ceil_seen) - q;
                q += (gap > 25) ? 5 : ((gap > 10) ? 3 : 1);
                n_rise++;
            end
            // floor takes priority over ceiling
            if (q < int'(floor_reg)) q = int'(floor_reg);
            else if (q > int'(ceil_seen)) q = int'(ceil_seen);
            if (q != prev) cooldown = 2'd1;
            cur_q = q[6:0];
        endfunction

        function void note_counters(counters_t c);
            bit traffic;
            int unsigned h;
            outcome_t o;
            h = link_health(c, traffic);
            step_quality(h, traffic);
            o.quality = cur_q;
            o.health  = h[13:0];
            o.traffic = traffic;
            expected_outcomes.push_back(o);
        endfunction

        function void check_outcome(quality_t q, health_t h, logic t);
            outcome_t o;
            if (expected_outcomes.size() == 0) begin
                errors++;
                $display("%0t: unexpected result quality %0d health %0d traffic %0b",
                         $time, q, h, t);
                return;
            end
            o = expected_outcomes.pop_front();
            checked++;
            if (q !== o.quality) begin
                errors++;
                if (errors < 100)
                    $display("%0t: quality expected %0d actual %0d", $time, o.quality, q);
            end
            if (h !== o.health) begin
                errors++;
                if (errors < 100)
                    $display("%0t: health expected %0d actual %0d", $time, o.health, h);
            end
            if (t !== o.traffic) begin
                errors++;
                if (errors < 100)
                    $display("%0t: had_traffic expected %0b actual %0b", $time, o.traffic, t);
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    apb_addr_t   paddr = '0;
    apb_data_t   pwdata = '0;
    apb_data_t   prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_fec_count = '0;
    logic [15:0] s_packet_id_count = '0;
    logic [15:0] s_frame_id_count = '0;
    logic [15:0] s_packets_received = '0;
    logic [15:0] s_frames_received = '0;
    logic [15:0] s_frames_lost = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    quality_t    m_quality;
    health_t     m_health_hundredths;
    logic        m_had_traffic;

    bit hold_req = 1'b0;
    bit hold_taken = 1'b0;

    link_quality_scoreboard sb = new();

    always #5 aclk = ~aclk;

    link_health_quality_controller #(
        .COUNT_WIDTH(16)
    ) dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_fec_count        (s_fec_count),
        .s_packet_id_count  (s_packet_id_count),
        .s_frame_id_count   (s_frame_id_count),
        .s_packets_received (s_packets_received),
        .s_frames_received  (s_frames_received),
        .s_frames_lost      (s_frames_lost),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_quality          (m_quality),
        .m_health_hundredths(m_health_hundredths),
        .m_had_traffic      (m_had_traffic)
    );

    // Transaction monitor on both channels
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_counters({s_fec_count, s_packet_id_count, s_frame_id_count,
                                  s_packets_received, s_frames_received, s_frames_lost});
            if (m_valid && m_ready)
                sb.check_outcome(m_quality, m_health_hundredths, m_had_traffic);
        end
    end

    // Result-side backpressure: busy patterns, short stall runs, one long hold-off
    initial begin : receiver
        int stall_left, busy_pct, span;
        stall_left = 0;
        busy_pct = 0;
        span = 0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                m_ready <= 1'b0;
                repeat (600) @(posedge aclk);
            end else if (stall_left > 0) begin
                stall_left = stall_left - 1;
                m_ready <= 1'b0;
            end else begin
                if (span == 0) begin
                    span = $urandom_range(100, 400);
                    case ($urandom_range(0, 3))
                        0: busy_pct = 0;
                        1: busy_pct = 15;
                        2: busy_pct = 50;
                        default: busy_pct = 80;
                    endcase
                end
                span = span - 1;
                if ($urandom_range(0, 199) == 0) stall_left = $urandom_range(5, 40);
                m_ready <= ($urandom_range(0, 99) >= busy_pct);
            end
        end
    end

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic counters_t udp_item(int got, int lost);
        counters_t c;
        c = {$urandom, $urandom, $urandom};
        c.got = got[15:0];
        c.lost = lost[15:0];
        return c;
    endfunction

    function automatic counters_t rel_item(int fec, int pid, int fid, int recv);
        counters_t c;
        c = {$urandom, $urandom, $urandom};
        c.fec = fec[15:0];
        c.pid = pid[15:0];
        c.fid = fid[15:0];
        c.recv = recv[15:0];
        return c;
    endfunction

    // Mostly counters aimed at a health band, plus idle intervals and raw noise
    function automatic counters_t random_item(bit rel);
        counters_t c;
        int kind, band, pm;
        longint unsigned want, total, got;
        c = {$urandom, $urandom, $urandom};
        kind = $urandom_range(0, 99);
        if (kind < 6) return c;
        if (kind < 12) begin
            c.got = '0;
            c.lost = '0;
            if ($urandom_range(0, 1)) c.fec = '0;
            else c.pid = '0;
            return c;
        end
        if (kind < 55) band = 0;
        else if (kind < 70) band = 1;
        else if (kind < 94) band = 2;
        else band = 3;
        if (rel) begin
            // health is the square of the delivery ratio
            case (band)
                0: pm = $urandom_range(988, 1010);
                1: pm = $urandom_range(949, 987);
                2: pm = $urandom_range(500, 948);
                default: pm = $urandom_range(0, 499);
            endcase
            c.fec = 16'($urandom_range(1, 8));
            c.fid = 16'($urandom_range(1, 8));
            c.pid = 16'($urandom_range(1, 8191));
            if ($urandom_range(0, 7) == 0) c.fec = 16'($urandom);
            want = (c.fec == 0) ? 64'd0 : (64'(c.pid) * 64'(c.fid)) / 64'(c.fec);
            total = want * pm / 1000;
            c.recv = (total > 65535) ? 16'hFFFF : total[15:0];
        end else begin
            case (band)
                0: pm = $urandom_range(975, 1010);
                1: pm = $urandom_range(900, 974);
                2: pm = $urandom_range(250, 899);
                default: pm = $urandom_range(0, 249);
            endcase
            total = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(1, 100))
                                                : 64'($urandom_range(1, 65535));
            got = total * pm / 1000;
            if (got > total) got = total;
            c.got = got[15:0];
            c.lost = 16'(total - got);
        end
        return c;
    endfunction

    task automatic send_item(counters_t c);
        s_valid            <= 1'b1;
        s_fec_count        <= c.fec;
        s_packet_id_count  <= c.pid;
        s_frame_id_count   <= c.fid;
        s_packets_received <= c.recv;
        s_frames_received  <= c.got;
        s_frames_lost      <= c.lost;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic pause_sender(int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.expected_outcomes.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    // Two-phase APB write; unused upper data bits get random junk half the time
    task automatic cfg_write(reg_idx_t idx, int unsigned val, int width);
        apb_data_t data;
        data = val;
        if ($urandom_range(0, 1)) data = data | ($urandom << width);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        sb.write_reg(idx, data);
    endtask

    task automatic apply_setting(bit auto_on, bit rel, int ceil_v, int floor_v);
        drain_results();
        cfg_write(REG_AUTO_ENABLE, auto_on, 1);
        cfg_write(REG_LINK_MODE, rel, 1);
        cfg_write(REG_QUALITY_CEILING, ceil_v, QUAL_W);
        cfg_write(REG_QUALITY_FLOOR, floor_v, QUAL_W);
    endtask

    initial begin
        int burst;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // reset config: adaptation off, UDP counters
        send_item(udp_item(65535, 0));
        send_item(udp_item(0, 0));
        drain_results();
        cfg_write(REG_AUTO_ENABLE, 1, 1);
        send_item(udp_item(0, 0));
        send_item(udp_item(0, 65535));
        send_item({6{16'hFFFF}});
        send_item(udp_item(1, 39));
        send_item(udp_item(100, 0));
        send_item(udp_item(100, 0));
        send_item(udp_item(50, 50));
        pause_sender(3);
        send_item(udp_item(975, 25));
        send_item(udp_item(975, 25));
        send_item(udp_item(9000, 1000));
        drain_results();
        cfg_write(REG_LINK_MODE, 1, 1);
        send_item(rel_item(0, 65535, 65535, 65535));
        send_item(rel_item(65535, 1, 1, 0));
        send_item(rel_item(1, 65535, 65535, 65535));
        send_item(rel_item(2, 100, 10, 500));
        send_item(rel_item(3, 100, 9, 65535));
        send_item(rel_item(1, 1000, 1, 990));
        send_item(rel_item(1, 1000, 1, 700));
        // zero floor: the decrease lands on 0, next interval restarts at ceiling
        apply_setting(1, 0, 4, 0);
        repeat (3) send_item(udp_item(100, 0));
        send_item(udp_item(27, 73));
        send_item(udp_item(100, 0));

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: apply_setting(1, 0, 75, 10);
                1: apply_setting(1, 1, 100, 1);
                2: apply_setting(1, 0, 127, 0);
                3: apply_setting(0, 1, 50, 20);
                4: apply_setting(1, 1, 30, 60);
                5: apply_setting(1, 0, 0, 1);
                6: apply_setting(1, 1, $urandom_range(0, 127), $urandom_range(0, 127));
                default: apply_setting(1, 0, $urandom_range(10, 100), $urandom_range(1, 30));
            endcase
            burst = $urandom_range(1, 24);
            for (int i = 0; i < 175; i++) begin
                if (p == 2 && i == 5) hold_req = 1'b1;
                send_item(random_item(sb.reliable));
                burst = burst - 1;
                if (burst == 0) begin
                    burst = $urandom_range(1, 24);
                    // keep offering back to back while the receiver holds off
                    if (!(p == 2 && i < 60))
                        pause_sender(($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                                 : $urandom_range(1, 12));
                end
            end
        end

        drain_results();
        repeat (100) @(posedge aclk);
        if (sb.expected_outcomes.size() != 0) begin
            sb.errors++;
            $display("%0t: %0d results never arrived", $time, sb.expected_outcomes.size());
        end
        $display("%0d intervals checked: %0d resets, %0d decreases, %0d increases, %0d idle",
                 sb.checked, sb.n_reset, sb.n_drop, sb.n_rise, sb.n_idle);
        $display("%0d register writes over UDP and reliable settings, long hold-off %0s",
                 sb.n_writes, hold_taken ? "done" : "missed");
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
